FILE: hdl/strict_priority_multi_queue_defines.svh
// Assertion macros shared by the queue checker.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SPMQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SPMQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication, sampled on the rising clock, off during reset.
`define SPMQ_ASSERT_LAT2(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

FILE: hdl/spmq_pkg.sv
// Shared constants and codes for the strict priority multi-level queue.
package spmq_pkg;

   localparam int LEVELS_DEF      = 8;
   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int TASK_BITS_DEF   = 16;

   localparam logic [3:0] NUM_LEVELS_RST = 4'd8;

   // request function codes (code 3 behaves as a query)
   localparam logic [1:0] FUNC_ENQ = 2'd0;
   localparam logic [1:0] FUNC_DEQ = 2'd1;
   localparam logic [1:0] FUNC_QRY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   // register byte address
   localparam logic [1:0] REG_NUM_LEVELS = 2'd0;

endpackage

FILE: hdl/spmq_csr.sv
// APB register block holding the active level count.
module spmq_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [3:0]  num_levels
);

   logic [3:0] num_levels_ff;
   logic [3:0] num_levels_in;
   logic       wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr == spmq_pkg::REG_NUM_LEVELS);

   always_comb begin
      num_levels_in = num_levels_ff;
      if (wr_hit) begin
         num_levels_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= spmq_pkg::NUM_LEVELS_RST;
      end else begin
         num_levels_ff <= num_levels_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = (paddr == spmq_pkg::REG_NUM_LEVELS) ? 32'(num_levels_ff) : 32'd0;
   assign num_levels = num_levels_ff;

endmodule

FILE: hdl/spmq_level_table.sv
// Per-level ring state (head, tail, fill): one write port, two registered read ports.
module spmq_level_table #(
   parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
   parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [$clog2(LEVELS)-1:0]              wr_addr,
   input  logic [2*$clog2(LEVEL_DEPTH)+$clog2(LEVEL_DEPTH+1)-1:0] wr_data,
   input  logic [$clog2(LEVELS)-1:0]              rd_a_addr,
   input  logic [$clog2(LEVELS)-1:0]              rd_b_addr,
   output logic [2*$clog2(LEVEL_DEPTH)+$clog2(LEVEL_DEPTH+1)-1:0] rd_a_data,
   output logic [2*$clog2(LEVEL_DEPTH)+$clog2(LEVEL_DEPTH+1)-1:0] rd_b_data
);

   localparam int ENT_W = 2*$clog2(LEVEL_DEPTH) + $clog2(LEVEL_DEPTH+1);

   logic [ENT_W-1:0] lvl_mem [LEVELS];
   logic [LEVELS-1:0] ent_vld_ff;
   logic [ENT_W-1:0] a_data_ff;
   logic [ENT_W-1:0] b_data_ff;
   logic             a_vld_ff;
   logic             b_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lvl_mem[wr_addr] <= wr_data;
      end
      a_data_ff <= lvl_mem[rd_a_addr];
      b_data_ff <= lvl_mem[rd_b_addr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            ent_vld_ff[wr_addr] <= 1'b1;
         end
         a_vld_ff <= ent_vld_ff[rd_a_addr];
         b_vld_ff <= ent_vld_ff[rd_b_addr];
      end
   end

   assign rd_a_data = a_vld_ff ? a_data_ff : '0;
   assign rd_b_data = b_vld_ff ? b_data_ff : '0;

endmodule

FILE: hdl/spmq_task_store.sv
// Task id RAM, one ring of LEVEL_DEPTH entries per level, registered read.
module spmq_task_store #(
   parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
   parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
   parameter int TASK_BITS   = spmq_pkg::TASK_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]  wr_addr,
   input  logic [TASK_BITS-1:0]                   wr_data,
   input  logic [$clog2(LEVELS*LEVEL_DEPTH)-1:0]  rd_addr,
   output logic [TASK_BITS-1:0]                   rd_data
);

   logic [TASK_BITS-1:0] task_mem [LEVELS*LEVEL_DEPTH];
   logic [TASK_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= task_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/strict_priority_multi_queue.sv
// Top level of the strict priority multi-level task queue.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. func selects enqueue, dequeue of the highest visible head, or query.
// Each item yields one result on the rsp_ ports, marked by rsp_strobe for a
// single cycle; the receiver cannot stall, so the result is simply presented.
// Timing: busy is high for one cycle, the execute state, and no new item is
// taken while it is high; rsp_strobe is registered from that state. The two
// steps are the registered read of the level table (pointers and fill of the
// requested level and of the current top level) followed by the registered
// read of the task RAM at the top level's head, while the updated pointers and
// any new task id are written back. Writes land before the next item's reads.
// Register num_levels sits at byte address 0 of the APB port; write it only
// while the queue is idle.
// Reset (synchronous) empties every level and sets num_levels to 8; no
// clearing pass is needed. Tasks at levels above num_levels stay held.
module strict_priority_multi_queue #(
   parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
   parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
   parameter int TASK_BITS   = spmq_pkg::TASK_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_task_id,
   input  logic [3:0]  req_priority_req,
   output logic        rsp_strobe,
   output logic        rsp_head_valid,
   output logic [15:0] rsp_head_task,
   output logic [3:0]  rsp_head_priority,
   output logic [7:0]  rsp_total_count,
   output logic [4:0]  rsp_level_count,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int FILL_W = $clog2(LEVEL_DEPTH+1);
   localparam int ENT_W  = 2*PTR_W + FILL_W;
   localparam int ADDR_W = $clog2(LEVELS*LEVEL_DEPTH);
   localparam int TOT_W  = $clog2(LEVELS*LEVEL_DEPTH+1);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff, state_in;

   logic [3:0]  num_levels;
   logic [4:0]  lv;
   logic        prio_ok;
   logic        accept;
   logic [LVL_W-1:0] top_pre;
   logic        hit_pre;

   // command registers, loaded on accept
   logic [1:0]           func_ff;
   logic [TASK_BITS-1:0] tid_ff;
   logic                 prio_ok_ff;
   logic [LVL_W-1:0]     q_ff;
   logic [LVL_W-1:0]     top_ff;
   logic                 top_hit_ff;

   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [TOT_W-1:0]  total_ff, total_in;

   // result registers
   logic        strobe_ff;
   logic        head_valid_ff, head_valid_in;
   logic [3:0]  head_prio_ff, head_prio_in;
   logic        use_tid_ff, use_tid_in;
   logic [4:0]  level_count_ff, level_count_in;
   logic [1:0]  status_ff, status_in;

   logic [LVL_W-1:0] lvl_rd_a_addr;
   logic [ENT_W-1:0] lvl_rd_a, lvl_rd_b, lvl_wr_data;
   logic             lvl_wr_en;
   logic [LVL_W-1:0] lvl_wr_addr;

   logic [PTR_W-1:0]  hd_a, tl_a, hd_b, tl_b, tl_a_nxt, hd_b_nxt;
   logic [FILL_W-1:0] fl_a, fl_b;

   logic              in_exec, is_enq, is_deq, enq_ok, deq_ok, new_top;
   logic              task_wr_en;
   logic [ADDR_W-1:0] task_wr_addr, task_rd_addr;
   logic [TASK_BITS-1:0] task_rd;

   spmq_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .num_levels (num_levels)
   );

   // visible level count: 0 acts as 1, above LEVELS acts as LEVELS
   always_comb begin
      if (num_levels == 4'd0) begin
         lv = 5'd1;
      end else if (5'(num_levels) > 5'(LEVELS)) begin
         lv = 5'(LEVELS);
      end else begin
         lv = 5'(num_levels);
      end
   end

   assign prio_ok = (req_priority_req != 4'd0) && (5'(req_priority_req) <= lv);
   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff == S_EXEC);

   // highest visible non-empty level
   always_comb begin
      top_pre = '0;
      hit_pre = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         if (nonempty_ff[i] && (5'(i) < lv)) begin
            top_pre = LVL_W'(i);
            hit_pre = 1'b1;
         end
      end
   end

   assign lvl_rd_a_addr = prio_ok ? LVL_W'(req_priority_req - 4'd1) : '0;

   spmq_level_table #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_level_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (lvl_wr_en),
      .wr_addr   (lvl_wr_addr),
      .wr_data   (lvl_wr_data),
      .rd_a_addr (lvl_rd_a_addr),
      .rd_b_addr (top_pre),
      .rd_a_data (lvl_rd_a),
      .rd_b_data (lvl_rd_b)
   );

   assign {hd_a, tl_a, fl_a} = lvl_rd_a;
   assign {hd_b, tl_b, fl_b} = lvl_rd_b;

   assign tl_a_nxt = (tl_a == PTR_W'(LEVEL_DEPTH-1)) ? '0 : PTR_W'(tl_a + 1'b1);
   assign hd_b_nxt = (hd_b == PTR_W'(LEVEL_DEPTH-1)) ? '0 : PTR_W'(hd_b + 1'b1);

   assign in_exec = (state_ff == S_EXEC);
   assign is_enq  = (func_ff == spmq_pkg::FUNC_ENQ);
   assign is_deq  = (func_ff == spmq_pkg::FUNC_DEQ);
   assign enq_ok  = is_enq && prio_ok_ff && (fl_a != FILL_W'(LEVEL_DEPTH));
   assign deq_ok  = is_deq && top_hit_ff;
   // an enqueue above the old top lands in an empty level: its task is the head
   assign new_top = enq_ok && (!top_hit_ff || (q_ff > top_ff));

   // one level write per item: enqueue target or dequeued top
   assign lvl_wr_en   = in_exec && (enq_ok || deq_ok);
   assign lvl_wr_addr = enq_ok ? q_ff : top_ff;
   assign lvl_wr_data = enq_ok ? {hd_a, tl_a_nxt, FILL_W'(fl_a + 1'b1)}
                               : {hd_b_nxt, tl_b, FILL_W'(fl_b - 1'b1)};

   assign task_wr_en   = in_exec && enq_ok;
   assign task_wr_addr = ADDR_W'(ADDR_W'(q_ff) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tl_a));
   assign task_rd_addr = ADDR_W'(ADDR_W'(top_ff) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(hd_b));

   spmq_task_store #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .TASK_BITS   (TASK_BITS)
   ) u_task_store (
      .clock   (clock),
      .wr_en   (task_wr_en),
      .wr_addr (task_wr_addr),
      .wr_data (tid_ff),
      .rd_addr (task_rd_addr),
      .rd_data (task_rd)
   );

   always_comb begin
      state_in       = state_ff;
      nonempty_in    = nonempty_ff;
      total_in       = total_ff;
      head_valid_in  = new_top || top_hit_ff;
      use_tid_in     = new_top;
      head_prio_in   = 4'd0;
      status_in      = spmq_pkg::ST_OK;
      level_count_in = 5'(fl_a);

      if (new_top) begin
         head_prio_in = 4'(5'(q_ff) + 5'd1);
      end else if (top_hit_ff) begin
         head_prio_in = 4'(5'(top_ff) + 5'd1);
      end

      if (is_enq) begin
         if (!prio_ok_ff) begin
            status_in = spmq_pkg::ST_BAD;
         end else if (!enq_ok) begin
            status_in = spmq_pkg::ST_FULL;
         end
      end else if (!top_hit_ff) begin
         status_in = spmq_pkg::ST_EMPTY;
      end else if (!prio_ok_ff) begin
         status_in = spmq_pkg::ST_BAD;
      end

      if (!prio_ok_ff) begin
         level_count_in = 5'd0;
      end else if (enq_ok) begin
         level_count_in = 5'(FILL_W'(fl_a + 1'b1));
      end else if (deq_ok && (q_ff == top_ff)) begin
         level_count_in = 5'(FILL_W'(fl_a - 1'b1));
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (enq_ok) begin
               nonempty_in[q_ff] = 1'b1;
               total_in = TOT_W'(total_ff + 1'b1);
            end
            if (deq_ok) begin
               total_in = TOT_W'(total_ff - 1'b1);
               if (fl_b == FILL_W'(1)) begin
                  nonempty_in[top_ff] = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         strobe_ff   <= 1'b0;
         nonempty_ff <= '0;
         total_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         strobe_ff   <= in_exec;
         nonempty_ff <= nonempty_in;
         total_ff    <= total_in;
      end
   end

   // payload: command on accept, result at the end of the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         tid_ff     <= TASK_BITS'(req_task_id);
         prio_ok_ff <= prio_ok;
         q_ff       <= lvl_rd_a_addr;
         top_ff     <= top_pre;
         top_hit_ff <= hit_pre;
      end
      if (in_exec) begin
         head_valid_ff  <= head_valid_in;
         head_prio_ff   <= head_prio_in;
         use_tid_ff     <= use_tid_in;
         level_count_ff <= level_count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_head_valid    = head_valid_ff;
   assign rsp_head_task     = !head_valid_ff ? 16'd0
                            : (use_tid_ff ? 16'(tid_ff) : 16'(task_rd));
   assign rsp_head_priority = head_prio_ff;
   assign rsp_total_count   = 8'(total_ff);
   assign rsp_level_count   = level_count_ff;
   assign rsp_status        = status_ff;

endmodule

FILE: hdl/spmq_checker.sv
// Port-level checker for the strict priority queue, bound to the top level.
`include "strict_priority_multi_queue_defines.svh"

module spmq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_head_valid,
   input logic [15:0] rsp_head_task,
   input logic [3:0]  rsp_head_priority,
   input logic [1:0]  rsp_status
);

   // every accepted command is answered with a result strobe
   `SPMQ_ASSERT_LAT2(a_latency, start && !busy, rsp_strobe, "result transfer missing")

   // busy holds off a new command while one executes, so results never come back to back
   `SPMQ_ASSERT_NEXT(a_strobe_gap, rsp_strobe, !rsp_strobe, "back to back result transfers")

   `SPMQ_ASSERT_NOW(a_no_head, rsp_strobe && !rsp_head_valid,
      (rsp_head_task == 16'd0) && (rsp_head_priority == 4'd0), "head fields set without a head")

   `SPMQ_ASSERT_NOW(a_empty, rsp_strobe && (rsp_status == spmq_pkg::ST_EMPTY),
      !rsp_head_valid, "empty status with a head reported")

   `SPMQ_ASSERT_NOW(a_head_prio, rsp_strobe && rsp_head_valid,
      rsp_head_priority != 4'd0, "reported head has no level")

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (.*);

FILE: verif/tb_strict_priority_multi_queue.sv
// Self-checking testbench for the strict priority multi-level task queue.
module tb_strict_priority_multi_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS      = spmq_pkg::LEVELS_DEF;
   localparam int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   // func code 3 is unused and behaves as a query
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic        head_valid;
      logic [15:0] head_task;
      logic [3:0]  head_priority;
      logic [7:0]  total_count;
      logic [4:0]  level_count;
      logic [1:0]  status;
   } queue_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = spmq_pkg::FUNC_QRY;
   logic [15:0] req_task_id = '0;
   logic [3:0]  req_priority_req = '0;
   logic        rsp_strobe;
   logic        rsp_head_valid;
   logic [15:0] rsp_head_task;
   logic [3:0]  rsp_head_priority;
   logic [7:0]  rsp_total_count;
   logic [4:0]  rsp_level_count;
   logic [1:0]  rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = spmq_pkg::REG_NUM_LEVELS;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // queue image kept alongside the block
   logic [15:0] task_ram [LEVELS][LEVEL_DEPTH];
   logic [3:0]  rd_ptr [LEVELS] = '{default: '0};
   logic [3:0]  wr_ptr [LEVELS] = '{default: '0};
   logic [4:0]  lvl_fill [LEVELS] = '{default: '0};
   logic [7:0]  all_fill = '0;
   logic [3:0]  cfg_levels = spmq_pkg::NUM_LEVELS_RST;

   queue_result_type pending_results [$];

   logic [3:0] level_settings [0:10] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9,
                                         4'd5, 4'd2, 4'd7, 4'd6, 4'd4};
   int setting_pick = 0;
   int sender_idle_pct = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int cycle_count = 0;

   strict_priority_multi_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_priority_req  (req_priority_req),
      .rsp_strobe        (rsp_strobe),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_task     (rsp_head_task),
      .rsp_head_priority (rsp_head_priority),
      .rsp_total_count   (rsp_total_count),
      .rsp_level_count   (rsp_level_count),
      .rsp_status        (rsp_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // register value 0 acts as one level, anything above LEVELS as LEVELS
   function automatic int visible_levels(input logic [3:0] setting);
      if (setting == 0) return 1;
      if (setting > LEVELS) return LEVELS;
      return int'(setting);
   endfunction

   function automatic int top_visible_level(input int lv);
      for (int i = lv - 1; i >= 0; i--)
         if (lvl_fill[i] != 0) return i;
      return -1;
   endfunction

   function automatic queue_result_type apply_queue_op(input logic [1:0] f,
                                                       input logic [15:0] tid,
                                                       input logic [3:0] pr);
      queue_result_type res;
      int lv;
      int top;
      int q;
      bit pr_ok;
      lv = visible_levels(cfg_levels);
      pr_ok = (pr >= 1) && (int'(pr) <= lv);
      res = '0;
      res.status = spmq_pkg::ST_OK;
      if (f == spmq_pkg::FUNC_ENQ) begin
         if (!pr_ok) begin
            res.status = spmq_pkg::ST_BAD;
         end else begin
            q = int'(pr) - 1;
            if (lvl_fill[q] >= LEVEL_DEPTH) begin
               res.status = spmq_pkg::ST_FULL;
            end else begin
               task_ram[q][wr_ptr[q]] = tid;
               wr_ptr[q] = (wr_ptr[q] == LEVEL_DEPTH - 1) ? '0 : wr_ptr[q] + 1'b1;
               lvl_fill[q]++;
               all_fill++;
            end
         end
         top = top_visible_level(lv);
         if (top >= 0) begin
            res.head_valid = 1'b1;
            res.head_task = task_ram[top][rd_ptr[top]];
            res.head_priority = 4'(top + 1);
         end
      end else begin
         top = top_visible_level(lv);
         if (top < 0) begin
            res.status = spmq_pkg::ST_EMPTY;
         end else begin
            res.head_valid = 1'b1;
            res.head_task = task_ram[top][rd_ptr[top]];
            res.head_priority = 4'(top + 1);
            if (f == spmq_pkg::FUNC_DEQ) begin
               rd_ptr[top] = (rd_ptr[top] == LEVEL_DEPTH - 1) ? '0 : rd_ptr[top] + 1'b1;
               lvl_fill[top]--;
               all_fill--;
            end
            res.status = pr_ok ? spmq_pkg::ST_OK : spmq_pkg::ST_BAD;
         end
      end
      res.total_count = all_fill;
      res.level_count = pr_ok ? lvl_fill[int'(pr) - 1] : '0;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] result %0d: %s", $realtime, results_checked, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result strobe with no transfer pending");
         end else begin
            want = pending_results.pop_front();
            check_field("head_valid", 16'(rsp_head_valid), 16'(want.head_valid));
            check_field("head_task", rsp_head_task, want.head_task);
            check_field("head_priority", 16'(rsp_head_priority), 16'(want.head_priority));
            check_field("total_count", 16'(rsp_total_count), 16'(want.total_count));
            check_field("level_count", 16'(rsp_level_count), 16'(want.level_count));
            check_field("status", 16'(rsp_status), 16'(want.status));
         end
         results_checked++;
      end
   end

   // start is dropped after each transfer; the block is busy for that cycle anyway
   task automatic issue_queue_op(input logic [1:0] f, input logic [15:0] tid,
                                 input logic [3:0] pr);
      @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      start <= 1'b1;
      req_func <= f;
      req_task_id <= tid;
      req_priority_req <= pr;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_queue_op(f, tid, pr));
      items_sent++;
      start <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write num_levels (random upper bits) and read it back
   task automatic write_num_levels(input logic [3:0] setting);
      logic [31:0] word;
      word = $urandom();
      word[3:0] = setting;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= spmq_pkg::REG_NUM_LEVELS;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cfg_levels = setting;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[3:0] !== setting)
         report_mismatch($sformatf("num_levels read 0x%0h after writing 0x%0h",
                                   prdata[3:0], setting));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_directed_ops();
      sender_idle_pct = 0;
      issue_queue_op(spmq_pkg::FUNC_QRY, 16'h0000, 4'd1);     // empty query
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'hFFFF, 4'd0);     // empty dequeue, bad priority
      issue_queue_op(FUNC_SPARE, 16'h1111, 4'd8);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'hFFFF, 4'd8);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h0000, 4'd1);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'hA5A5, 4'd0);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h5A5A, 4'd9);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h1234, 4'd15);
      issue_queue_op(spmq_pkg::FUNC_QRY, 16'h0000, 4'd0);     // bad priority, queue not empty
      issue_queue_op(FUNC_SPARE, 16'h0000, 4'd8);
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd1);
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd12);
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd1);
   endtask

   // tasks above the active level count stay held but invisible
   task automatic test_hidden_levels();
      sender_idle_pct = 0;
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h7001, 4'd7);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h7002, 4'd7);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h2001, 4'd2);
      wait_idle();
      write_num_levels(4'd3);
      issue_queue_op(spmq_pkg::FUNC_QRY, 16'h0000, 4'd7);
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd2);
      issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd1);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h3003, 4'd3);
      wait_idle();
      write_num_levels(4'd0);
      issue_queue_op(spmq_pkg::FUNC_QRY, 16'h0000, 4'd1);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h1001, 4'd1);
      issue_queue_op(spmq_pkg::FUNC_ENQ, 16'h1002, 4'd2);
      wait_idle();
      write_num_levels(4'd15);
      repeat (4) issue_queue_op(spmq_pkg::FUNC_DEQ, 16'h0000, 4'd7);
   endtask

   // alternating fill and drain waves, often aimed at one level to reach full
   task automatic test_random_mix(input int idle_pct, input int item_total);
      int sent;
      int wave_left;
      int lv;
      int hot;
      int r;
      bit filling;
      bit use_hot;
      logic [1:0] f;
      logic [3:0] pr;
      sender_idle_pct = idle_pct;
      sent = 0;
      wave_left = 0;
      filling = 1'b0;
      lv = 1;
      hot = 1;
      use_hot = 1'b0;
      while (sent < item_total) begin
         if (sent % 130 == 0) begin
            wait_idle();
            write_num_levels(level_settings[setting_pick % 11]);
            setting_pick++;
            lv = visible_levels(cfg_levels);
         end
         if (wave_left == 0) begin
            filling = !filling;
            wave_left = $urandom_range(48, 8);
            use_hot = ($urandom_range(99) < 40);
            hot = $urandom_range(lv, 1);
         end
         r = $urandom_range(99);
         if (r < (filling ? 65 : 20))
            f = spmq_pkg::FUNC_ENQ;
         else if (r < 88)
            f = spmq_pkg::FUNC_DEQ;
         else if (r < 96)
            f = spmq_pkg::FUNC_QRY;
         else
            f = FUNC_SPARE;
         if ($urandom_range(99) < 90)
            pr = use_hot ? 4'(hot) : 4'($urandom_range(lv, 1));
         else
            pr = 4'($urandom_range(15));
         issue_queue_op(f, 16'($urandom_range(16'hFFFF)), pr);
         wave_left--;
         sent++;
         if ($urandom_range(59) == 0)
            wait_idle();
      end
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_hidden_levels();
      test_random_mix(14, 650);
      test_random_mix(84, 650);
      test_random_mix(0, 650);
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d transfers over %0d level-count settings,",
               results_checked, items_sent, setting_pick + 3);
      $display("with sender gaps at 14%%, 84%% and none; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
